### rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pmss_pkg.sv
`default_nettype none

package pmss_pkg;

    // default parameter values
    localparam int HIST_LEN_DEF     = 5;
    localparam int SNAP_TIMEOUT_DEF = 500;

    // datapath widths
    localparam int P_W   = 25;  // rotated motion, q14
    localparam int Q_W   = 32;  // rotated motion times multiplier
    localparam int N_W   = 34;  // dividend magnitude
    localparam int DEN_W = 24;  // product of three divisors
    localparam int RES_W = 17;  // residue, signed q.16
    localparam int T_W   = 36;  // residue plus quotient

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SCROLL_DIV = 3'd0,
        REG_ENC_DIV    = 3'd1,
        REG_FINE_DIV   = 3'd2,
        REG_ROUGH_MUL  = 3'd3,
        REG_COS        = 3'd4,
        REG_SIN        = 3'd5,
        REG_SNAP_EN    = 3'd6,
        REG_INVERT     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } t_step;

    typedef struct packed {
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic              scroll_active;
        logic              encoder_active;
        logic              encoder_select;
        logic              fine_layer_on;
        logic              rough_layer_on;
        logic              encoder_snap_on;
        logic [31:0]       now_ms;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] cursor_x;
        logic signed [7:0] cursor_y;
        logic signed [7:0] scroll_h;
        logic signed [7:0] scroll_v;
        logic [1:0]        encoder_h_step;
        logic [1:0]        encoder_v_step;
        logic [1:0]        encoder_base_id;
    } t_out_word;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### rtl/pmss_div.sv
`default_nettype none

module pmss_div #(
    parameter int NUM_W = pmss_pkg::N_W,
    parameter int DEN_W = pmss_pkg::DEN_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]     i_den,
    output pmss_pkg::t_div_stat       o_status,
    output logic      [NUM_W-1:0]     o_quo
);
    import pmss_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign ge      = !diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quo         = r_quo;

endmodule

`default_nettype wire

### rtl/pointer_motion_scroll_snap.sv
// Trackball motion report processor with scroll, pseudo-encoder and axis snap.
// Input channel: i_in_valid / o_in_stall carrying one motion word (deltas, mode
// flags, millisecond time). A word is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carrying one result word per input.
// Configuration: APB-style port, eight registers read as 32-bit words at byte
// address 4*i; write them only while the block is idle (the block does not
// enforce this); pready is tied high. Each word runs through a bit-serial
// rotation, a bit-serial multiply, a restoring divider (one quotient bit a
// cycle) and the states that launch the divider, see it finish, finish the
// rounding and load the output.
// The input is stalled while a word is in flight; the next word is taken as
// soon as the result sits in the output register, even if it is still held.
// When the receiver stalls, the result waits in the output register and the
// block waits with the following result until the register is free.
// Synchronous reset clears residues, snap state and the output valid, and
// loads the register reset values (cosine 16384, everything else zero).
`default_nettype none
`include "assert_macros.svh"

module pointer_motion_scroll_snap #(
    parameter int HISTORY_LENGTH  = pmss_pkg::HIST_LEN_DEF,
    parameter int SNAP_TIMEOUT_MS = pmss_pkg::SNAP_TIMEOUT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pmss_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pmss_pkg::t_out_word      o_out_word,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import pmss_pkg::*;

    localparam int          FW      = $clog2(HISTORY_LENGTH + 1);
    localparam int          HALF    = HISTORY_LENGTH / 2;
    localparam logic [31:0] TIMEOUT = 32'(SNAP_TIMEOUT_MS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_M,
        ST_DIV_GO,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [7:0]       whole;
        logic signed [RES_W-1:0] res;
    } t_fin;

    // truncate toward zero, keep the signed fraction, saturate the whole part
    function automatic t_fin finish(input logic [N_W-1:0] q, input logic neg,
                                    input logic signed [RES_W-1:0] res);
        logic signed [T_W-1:0] t;
        logic [T_W-1:0]        mag;
        logic [T_W-17:0]       wm;
        logic [15:0]           frac;
        t_fin                  f;
        t    = (neg ? -$signed({2'b00, q}) : $signed({2'b00, q})) + T_W'(res);
        mag  = t[T_W-1] ? $unsigned(-t) : $unsigned(t);
        wm   = mag[T_W-1:16];
        frac = mag[15:0];
        if (!t[T_W-1]) begin
            f.whole = (wm > (T_W-16)'(127)) ? 8'sd127 : $signed(wm[7:0]);
            f.res   = $signed({1'b0, frac});
        end else begin
            f.whole = (wm > (T_W-16)'(128)) ? -8'sd128 : $signed(-wm[7:0]);
            f.res   = -$signed({1'b0, frac});
        end
        return f;
    endfunction

    function automatic logic signed [7:0] clamp127(input logic signed [7:0] v);
        return (v == -8'sd128) ? -8'sd127 : v;
    endfunction

    // configuration registers
    logic [7:0]         r_sdiv, r_ediv, r_fdiv, r_rmul;
    logic signed [15:0] r_cos, r_sin;
    logic               r_snap_en, r_invert;

    // control and datapath
    t_state                  r_state;
    t_in_word                r_in;
    logic [2:0]              r_cnt;
    logic [7:0]              r_dx, r_dy, r_m;
    logic signed [P_W-1:0]   r_cs, r_ss, r_px, r_py;
    logic signed [Q_W-1:0]   r_mx, r_my, r_qx, r_qy;
    logic [15:0]             r_d12;
    logic [DEN_W-1:0]        r_den;
    logic                    r_negx, r_negy;
    logic signed [RES_W-1:0] r_res_x, r_res_y;
    logic signed [7:0]       r_x, r_y;

    // snap state
    logic                    r_started;
    logic [FW-1:0]           r_fill;
    logic [HISTORY_LENGTH-1:0] r_hist;
    t_axis                   r_axis;
    logic [31:0]             r_last;

    logic                    r_ovalid;
    t_out_word               r_oword;

    // next values from the snap logic
    logic                    n_started;
    logic [FW-1:0]           n_fill;
    logic [HISTORY_LENGTH-1:0] n_hist;
    t_axis                   n_axis;
    logic [31:0]             n_last;
    t_out_word               n_oword;

    logic                    accept, out_free, last_bit;
    logic [7:0]              div_a, div_b, div_c;
    logic signed [P_W-1:0]   step_x, step_y;
    logic [N_W-1:0]          num_x, num_y, quo_x, quo_y;
    logic                    div_start;
    t_div_stat               div_stat_x, div_stat_y;
    t_fin                    fin_x, fin_y;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;
    assign last_bit   = (r_cnt == 3'd7);
    assign pready     = 1'b1;

    // register read back
    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_SCROLL_DIV: prdata = {24'd0, r_sdiv};
            REG_ENC_DIV:    prdata = {24'd0, r_ediv};
            REG_FINE_DIV:   prdata = {24'd0, r_fdiv};
            REG_ROUGH_MUL:  prdata = {24'd0, r_rmul};
            REG_COS:        prdata = 32'(r_cos);
            REG_SIN:        prdata = 32'(r_sin);
            REG_SNAP_EN:    prdata = {31'd0, r_snap_en};
            REG_INVERT:     prdata = {31'd0, r_invert};
            default:        prdata = '0;
        endcase
    end

    // active divisors for the incoming word
    assign div_a = (i_in_word.scroll_active && r_sdiv != 8'd0) ? r_sdiv : 8'd1;
    assign div_b = (i_in_word.encoder_active && r_ediv != 8'd0) ? r_ediv : 8'd1;
    assign div_c = (r_in.fine_layer_on && r_fdiv != 8'd0) ? r_fdiv : 8'd1;

    // one bit of each delta per cycle, top bit weighs negative
    always_comb begin
        step_x = (r_dx[0] ? r_cs : '0) - (r_dy[0] ? r_ss : '0);
        step_y = (r_dx[0] ? r_ss : '0) + (r_dy[0] ? r_cs : '0);
    end

    // dividend magnitudes, four times the product
    assign num_x     = r_qx[Q_W-1] ? -{r_qx, 2'b00} : {r_qx, 2'b00};
    assign num_y     = r_qy[Q_W-1] ? -{r_qy, 2'b00} : {r_qy, 2'b00};
    assign div_start = (r_state == ST_DIV_GO);

    pmss_div #(.NUM_W(N_W), .DEN_W(DEN_W)) u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (num_x),
        .i_den    (r_den),
        .o_status (div_stat_x),
        .o_quo    (quo_x)
    );

    pmss_div #(.NUM_W(N_W), .DEN_W(DEN_W)) u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (num_y),
        .i_den    (r_den),
        .o_status (div_stat_y),
        .o_quo    (quo_y)
    );

    assign fin_x = finish(quo_x, r_negx, r_res_x);
    assign fin_y = finish(quo_y, r_negy, r_res_y);

    // snap and output mapping
    logic                      restart, hbit, do_snap;
    logic [HISTORY_LENGTH-1:0] hist0, hist1;
    logic [FW-1:0]             fill0, fill1, ones;
    t_axis                     axis0, chosen;
    logic [8:0]                ax, ay;
    logic signed [7:0]         h, v;

    always_comb begin
        restart = !r_started || ((r_in.now_ms - r_last) > TIMEOUT);
        hist0   = restart ? '0 : r_hist;
        fill0   = restart ? '0 : r_fill;
        axis0   = restart ? AXIS_NONE : r_axis;
        ax      = r_x[7] ? -{r_x[7], r_x} : {r_x[7], r_x};
        ay      = r_y[7] ? -{r_y[7], r_y} : {r_y[7], r_y};
        if (axis0 == AXIS_X) begin
            hbit = !({2'b00, ay} > {ax, 2'b00});
        end else begin
            hbit = ({2'b00, ax} > {ay, 2'b00});
        end
        hist1 = {hist0[HISTORY_LENGTH-2:0], hbit};
        fill1 = (fill0 < FW'(HISTORY_LENGTH)) ? fill0 + 1'b1 : fill0;
        ones  = '0;
        for (int i = 0; i < HISTORY_LENGTH; i++) begin
            ones = ones + FW'(hist1[i]);
        end
        // majority with a two-sample guard against flipping
        priority if (axis0 == AXIS_X && ones <= FW'(HALF) && hist1[1:0] == 2'b00) begin
            chosen = AXIS_Y;
        end else if (axis0 == AXIS_Y && ones > FW'(HALF) && hist1[1:0] == 2'b11) begin
            chosen = AXIS_X;
        end else if (axis0 == AXIS_NONE) begin
            chosen = (ones <= FW'(HALF)) ? AXIS_Y : AXIS_X;
        end else begin
            chosen = axis0;
        end
        do_snap = (r_in.scroll_active && r_snap_en)
               || (r_in.encoder_active && r_in.encoder_snap_on);

        n_started = r_started;
        n_fill    = r_fill;
        n_hist    = r_hist;
        n_axis    = r_axis;
        n_last    = r_last;
        h         = '0;
        v         = '0;
        n_oword   = '0;
        n_oword.cursor_x = r_x;
        n_oword.cursor_y = r_y;

        if (r_in.scroll_active || r_in.encoder_active) begin
            if (r_x != 8'sd0 || r_y != 8'sd0) begin
                if (do_snap) begin
                    n_started = 1'b1;
                    n_fill    = fill1;
                    n_hist    = hist1;
                    n_last    = r_in.now_ms;
                    n_axis    = axis0;
                    if (fill1 == FW'(HISTORY_LENGTH)) begin
                        n_axis = chosen;
                        if (chosen == AXIS_X) begin
                            h = clamp127(r_x);
                        end else begin
                            v = -clamp127(r_y);
                        end
                    end
                end else begin
                    h = clamp127(r_x);
                    v = -clamp127(r_y);
                end
                if (r_in.scroll_active && r_invert) begin
                    h = -h;
                    v = -v;
                end
                if (r_in.encoder_active) begin
                    n_oword.encoder_h_step = h[7] ? STEP_CCW :
                                             (h != 8'sd0 ? STEP_CW : STEP_NONE);
                    n_oword.encoder_v_step = v[7] ? STEP_CCW :
                                             (v != 8'sd0 ? STEP_CW : STEP_NONE);
                    n_oword.encoder_base_id = {r_in.encoder_select, 1'b0};
                end
                if (r_in.scroll_active) begin
                    n_oword.scroll_h = h;
                    n_oword.scroll_v = v;
                end
            end
            n_oword.cursor_x = '0;
            n_oword.cursor_y = '0;
        end else begin
            n_started = 1'b0;
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_sdiv    <= '0;
            r_ediv    <= '0;
            r_fdiv    <= '0;
            r_rmul    <= '0;
            r_cos     <= 16'sd16384;
            r_sin     <= '0;
            r_snap_en <= 1'b0;
            r_invert  <= 1'b0;
            r_res_x   <= '0;
            r_res_y   <= '0;
            r_started <= 1'b0;
            r_fill    <= '0;
            r_hist    <= '0;
            r_axis    <= AXIS_NONE;
            r_last    <= '0;
        end else begin
            // configuration write
            if (psel && penable && pwrite) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_SCROLL_DIV: r_sdiv    <= pwdata[7:0];
                    REG_ENC_DIV:    r_ediv    <= pwdata[7:0];
                    REG_FINE_DIV:   r_fdiv    <= pwdata[7:0];
                    REG_ROUGH_MUL:  r_rmul    <= pwdata[7:0];
                    REG_COS:        r_cos     <= $signed(pwdata[15:0]);
                    REG_SIN:        r_sin     <= $signed(pwdata[15:0]);
                    REG_SNAP_EN:    r_snap_en <= pwdata[0];
                    REG_INVERT:     r_invert  <= pwdata[0];
                    default:        r_invert  <= r_invert;
                endcase
            end

            // output valid: load a new result or clear once taken
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_in    <= i_in_word;
                        r_cs    <= P_W'(r_cos);
                        r_ss    <= P_W'(r_sin);
                        r_dx    <= i_in_word.delta_x;
                        r_dy    <= i_in_word.delta_y;
                        r_px    <= '0;
                        r_py    <= '0;
                        r_cnt   <= '0;
                        r_d12   <= {8'd0, div_a} * {8'd0, div_b};
                        r_m     <= (i_in_word.rough_layer_on && r_rmul != 8'd0)
                                   ? r_rmul : 8'd1;
                        r_state <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    if (r_cnt == 3'd0) begin
                        r_den <= {8'd0, r_d12} * {16'd0, div_c};
                    end
                    r_px  <= last_bit ? r_px - step_x : r_px + step_x;
                    r_py  <= last_bit ? r_py - step_y : r_py + step_y;
                    r_cs  <= r_cs <<< 1;
                    r_ss  <= r_ss <<< 1;
                    r_dx  <= r_dx >> 1;
                    r_dy  <= r_dy >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_bit) begin
                        r_state <= ST_MUL_M;
                    end
                end
                ST_MUL_M: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_m   <= r_m >> 1;
                    if (r_cnt == 3'd0) begin
                        r_qx <= r_m[0] ? Q_W'(r_px) : '0;
                        r_qy <= r_m[0] ? Q_W'(r_py) : '0;
                        r_mx <= Q_W'(r_px) <<< 1;
                        r_my <= Q_W'(r_py) <<< 1;
                    end else begin
                        r_qx <= r_m[0] ? r_qx + r_mx : r_qx;
                        r_qy <= r_m[0] ? r_qy + r_my : r_qy;
                        r_mx <= r_mx <<< 1;
                        r_my <= r_my <<< 1;
                    end
                    if (last_bit) begin
                        r_state <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    r_negx  <= r_qx[Q_W-1];
                    r_negy  <= r_qy[Q_W-1];
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat_x.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_x     <= fin_x.whole;
                    r_y     <= fin_y.whole;
                    r_res_x <= fin_x.res;
                    r_res_y <= fin_y.res;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_oword   <= n_oword;
                        r_started <= n_started;
                        r_fill    <= n_fill;
                        r_hist    <= n_hist;
                        r_axis    <= n_axis;
                        r_last    <= n_last;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == ST_MUL_P)
    `ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= FW'(HISTORY_LENGTH))
    `ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, div_stat_x.done, r_state == ST_DIV)
    `ASSERT_IMPL(a_axis_full, i_clk, i_rst_n, r_axis != AXIS_NONE, r_fill == FW'(HISTORY_LENGTH))
    `ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, div_stat_x == div_stat_y)

endmodule

`default_nettype wire

### sim/pointer_motion_scroll_snap_test.sv
`timescale 1ns / 1ps
`default_nettype none

module pointer_motion_scroll_snap_test;
    import pmss_pkg::*;

    localparam int HIST_LEN     = 5;
    localparam int SNAP_TIMEOUT = 500;
    localparam int LATENCY      = 80;
    localparam int WATCHDOG     = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pointer_motion_scroll_snap dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [7:0]          m_scroll_div, m_enc_div, m_fine_div, m_rough_mul;
    logic signed [15:0]  m_cos, m_sin;
    logic                m_snap_en, m_invert;
    longint              m_res_x, m_res_y;
    logic                m_snap_started;
    int                  m_fill;
    logic [4:0]          m_hist;
    t_axis               m_axis;
    logic [31:0]         m_last_time;

    t_out_word expected_words[$];
    int  errors = 0;
    int  n_sent = 0, n_checked = 0, n_scroll = 0, n_enc = 0;
    int  idle_cycles = 0;
    bit  long_hold = 0, bursty = 1, stall_on = 1;
    int  stall_pct = 30;

    function automatic int motion_step(longint p, longint mul, longint dv, inout longint res);
        longint t, whole;
        t = (p * mul * 4) / dv + res;
        whole = t / 65536;
        res = t - whole * 65536;
        if (whole > 127) whole = 127;
        if (whole < -128) whole = -128;
        return int'(whole);
    endfunction

    function automatic int clip127(int v);
        return v > 127 ? 127 : (v < -127 ? -127 : v);
    endfunction

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_axis vote_axis(t_axis cur, logic [4:0] h);
        int ones;
        ones = $countones(h);
        if (cur == AXIS_X && ones <= HIST_LEN / 2 && h[1:0] == 2'b00) return AXIS_Y;
        if (cur == AXIS_Y && ones > HIST_LEN / 2 && h[1:0] == 2'b11) return AXIS_X;
        if (cur == AXIS_NONE) return ones <= HIST_LEN / 2 ? AXIS_Y : AXIS_X;
        return cur;
    endfunction

    function automatic t_step step_of(int v);
        return v > 0 ? STEP_CW : (v < 0 ? STEP_CCW : STEP_NONE);
    endfunction

    // work out the result word for one motion word
    function automatic t_out_word predict_motion(t_in_word w);
        t_out_word r;
        longint dv, mul, c, s;
        int x, y, h, v;
        logic snap;
        dv = 1; mul = 1; c = m_cos; s = m_sin; h = 0; v = 0;
        r = '0;
        if (w.scroll_active && m_scroll_div != 0) dv *= m_scroll_div;
        if (w.encoder_active && m_enc_div != 0) dv *= m_enc_div;
        if (w.fine_layer_on && m_fine_div != 0) dv *= m_fine_div;
        if (w.rough_layer_on && m_rough_mul != 0) mul = m_rough_mul;
        x = motion_step(c * w.delta_x - s * w.delta_y, mul, dv, m_res_x);
        y = motion_step(s * w.delta_x + c * w.delta_y, mul, dv, m_res_y);
        if (w.scroll_active || w.encoder_active) begin
            snap = (w.scroll_active && m_snap_en) || (w.encoder_active && w.encoder_snap_on);
            if (x != 0 || y != 0) begin
                if (snap) begin
                    if (!m_snap_started || (w.now_ms - m_last_time) > SNAP_TIMEOUT) begin
                        m_snap_started = 1'b1;
                        m_fill = 0;
                        m_hist = '0;
                        m_axis = AXIS_NONE;
                    end
                    m_last_time = w.now_ms;
                    if (m_axis == AXIS_X)
                        m_hist = {m_hist[3:0], !(magnitude(y) > magnitude(x) * 4)};
                    else
                        m_hist = {m_hist[3:0], (magnitude(x) > magnitude(y) * 4)};
                    if (m_fill < HIST_LEN) m_fill++;
                    if (m_fill == HIST_LEN) begin
                        m_axis = vote_axis(m_axis, m_hist);
                        if (m_axis == AXIS_X) h = clip127(x);
                        else v = -clip127(y);
                    end
                end else begin
                    h = clip127(x);
                    v = -clip127(y);
                end
                if (w.scroll_active && m_invert) begin
                    h = -h;
                    v = -v;
                end
                if (w.encoder_active) begin
                    r.encoder_h_step = step_of(h);
                    r.encoder_v_step = step_of(v);
                    r.encoder_base_id = {w.encoder_select, 1'b0};
                end
                if (!w.scroll_active) begin
                    h = 0;
                    v = 0;
                end
            end
            x = 0;
            y = 0;
        end else begin
            m_snap_started = 1'b0;
        end
        r.cursor_x = x[7:0];
        r.cursor_y = y[7:0];
        r.scroll_h = h[7:0];
        r.scroll_v = v[7:0];
        return r;
    endfunction

    // receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (long_hold) i_out_stall <= 1'b1;
        else i_out_stall <= stall_on && ($urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_words.pop_front();
                n_checked++;
                if (o_out_word.cursor_x !== e.cursor_x) begin
                    $error("cursor_x exp %0d got %0d", e.cursor_x, o_out_word.cursor_x);
                    errors++;
                end
                if (o_out_word.cursor_y !== e.cursor_y) begin
                    $error("cursor_y exp %0d got %0d", e.cursor_y, o_out_word.cursor_y);
                    errors++;
                end
                if (o_out_word.scroll_h !== e.scroll_h) begin
                    $error("scroll_h exp %0d got %0d", e.scroll_h, o_out_word.scroll_h);
                    errors++;
                end
                if (o_out_word.scroll_v !== e.scroll_v) begin
                    $error("scroll_v exp %0d got %0d", e.scroll_v, o_out_word.scroll_v);
                    errors++;
                end
                if (o_out_word.encoder_h_step !== e.encoder_h_step) begin
                    $error("encoder_h_step exp %0d got %0d", e.encoder_h_step,
                           o_out_word.encoder_h_step);
                    errors++;
                end
                if (o_out_word.encoder_v_step !== e.encoder_v_step) begin
                    $error("encoder_v_step exp %0d got %0d", e.encoder_v_step,
                           o_out_word.encoder_v_step);
                    errors++;
                end
                if (o_out_word.encoder_base_id !== e.encoder_base_id) begin
                    $error("encoder_base_id exp %0d got %0d", e.encoder_base_id,
                           o_out_word.encoder_base_id);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else if (expected_words.size() != 0 || i_in_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SCROLL_DIV: m_scroll_div = val[7:0];
            REG_ENC_DIV:    m_enc_div = val[7:0];
            REG_FINE_DIV:   m_fine_div = val[7:0];
            REG_ROUGH_MUL:  m_rough_mul = val[7:0];
            REG_COS:        m_cos = val[15:0];
            REG_SIN:        m_sin = val[15:0];
            REG_SNAP_EN:    m_snap_en = val[0];
            REG_INVERT:     m_invert = val[0];
            default: ;
        endcase
    endtask

    // stop offering and wait until every expected word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic configure(int sdiv, int ediv, int fdiv, int rmul, int c, int s,
                             bit snap, bit inv);
        drain();
        write_reg(REG_SCROLL_DIV, sdiv);
        write_reg(REG_ENC_DIV, ediv);
        write_reg(REG_FINE_DIV, fdiv);
        write_reg(REG_ROUGH_MUL, rmul);
        write_reg(REG_COS, c);
        write_reg(REG_SIN, s);
        write_reg(REG_SNAP_EN, snap);
        write_reg(REG_INVERT, inv);
    endtask

    // offer one word and hold it until taken
    task automatic send_word(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_words.push_back(predict_motion(w));
        n_sent++;
        if (w.scroll_active) n_scroll++;
        if (w.encoder_active) n_enc++;
        if (bursty && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    logic [31:0] clock_ms = 0;

    function automatic t_in_word random_word(int mode);
        t_in_word w;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        w = rnd[$bits(t_in_word)-1:0];
        case (mode)
            0: begin w.scroll_active = 0; w.encoder_active = 0; end
            1: begin w.scroll_active = 1; w.encoder_active = 0; end
            2: begin w.scroll_active = 0; w.encoder_active = 1; end
            default: ;
        endcase
        // mostly small time steps to stay inside the snap window
        case ($urandom_range(9))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + SNAP_TIMEOUT + $urandom_range(1, 5000);
            2: clock_ms = clock_ms + SNAP_TIMEOUT;
            default: clock_ms = clock_ms + $urandom_range(0, 40);
        endcase
        w.now_ms = clock_ms;
        return w;
    endfunction

    task automatic test_directed();
        t_in_word w;
        configure(0, 0, 0, 0, 16384, 0, 0, 0);
        w = '0; send_word(w);
        w.delta_x = 127; w.delta_y = -128; send_word(w);
        w.delta_x = -128; w.delta_y = 127; send_word(w);
        w.rough_layer_on = 1; send_word(w);
        configure(3, 5, 7, 255, -16384, 16384, 1, 1);
        w = '0; w.delta_x = -128; w.delta_y = -128; w.rough_layer_on = 1; send_word(w);
        w.delta_x = 1; w.delta_y = 0; w.rough_layer_on = 0; w.fine_layer_on = 1; send_word(w);
        w.fine_layer_on = 0; w.scroll_active = 1; w.delta_x = 127; w.delta_y = 3;
        for (int i = 0; i < 7; i++) begin
            w.now_ms = 32'hFFFF_FF00 + i * 30; send_word(w);
        end
        w.now_ms = w.now_ms + SNAP_TIMEOUT + 1; send_word(w);
        w.delta_x = 0; w.delta_y = 0; send_word(w);
        w.scroll_active = 0; w.encoder_active = 1; w.encoder_select = 1;
        w.encoder_snap_on = 1; w.delta_y = -90; send_word(w);
        w.scroll_active = 1; w.encoder_snap_on = 0; w.delta_x = 40; send_word(w);
        // out-of-range rotation values
        configure(255, 255, 255, 1, 16'h8000, 16'h7FFF, 0, 0);
        w = '0; w.delta_x = 127; w.delta_y = 127; w.scroll_active = 1;
        w.encoder_active = 1; w.fine_layer_on = 1; send_word(w);
        w.scroll_active = 0; w.encoder_active = 0; w.fine_layer_on = 0; send_word(w);
    endtask

    task automatic test_random(int count, int mode);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) bursty = $urandom_range(1);
            send_word(random_word(mode < 0 ? $urandom_range(3) : mode));
        end
    endtask

    task automatic test_settings();
        int c, s;
        for (int k = 0; k < 6; k++) begin
            c = $urandom_range(0, 32768) - 16384;
            s = $urandom_range(0, 32768) - 16384;
            configure($urandom_range(0, 255), $urandom_range(0, 255) % 9,
                      $urandom_range(0, 4), $urandom_range(0, 3), c, s,
                      $urandom_range(1), $urandom_range(1));
            test_random(60, -1);
        end
    endtask

    task automatic test_snap_scroll();
        configure(2, 2, 0, 0, 16384, 0, 1, 0);
        test_random(120, 1);
        configure(0, 1, 0, 0, 11585, 11585, 1, 1);
        test_random(100, 2);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        configure(1, 1, 1, 2, 15000, -6000, 0, 0);
        stall_on = 1;
        long_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            test_random(20, -1);
        join
        stall_pct = 0;
        test_random(60, -1);
        stall_pct = 80;
        test_random(30, -1);
        stall_pct = 30;
        drain();
    endtask

    initial begin
        m_scroll_div = 0; m_enc_div = 0; m_fine_div = 0; m_rough_mul = 0;
        m_cos = 16384; m_sin = 0; m_snap_en = 0; m_invert = 0;
        m_res_x = 0; m_res_y = 0; m_snap_started = 0; m_fill = 0;
        m_hist = '0; m_axis = AXIS_NONE; m_last_time = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_settings();
        test_snap_scroll();
        test_backpressure();
        drain();
        $display("covered %0d words, %0d checked (%0d scroll, %0d encoder)",
                 n_sent, n_checked, n_scroll, n_enc);
        $display("register extremes, axis snap with restarts and a long receiver hold-off");
        if (errors == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/pmss_pkg.sv
rtl/pmss_div.sv
rtl/pointer_motion_scroll_snap.sv
sim/pointer_motion_scroll_snap_test.sv
